/* sv/ssq_pkg.sv */
// Package for the stepper step sequencer: opcodes, register indexes,
// configuration struct, reset values and coil pattern tables.
// No dependencies.
package ssq_pkg;

    // Default width of the remaining-step counter.
    localparam int COUNT_WIDTH_DEF = 16;

    // Field widths fixed by the command and result formats.
    localparam int MOVE_WIDTH = 16;
    localparam int POS_WIDTH  = 16;
    localparam int REM_WIDTH  = 16;
    localparam int COIL_WIDTH = 4;
    localparam int CFG_IDX_WIDTH  = 8;
    localparam int CFG_DATA_WIDTH = 16;

    // Command opcodes.
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_MOVE = 1'b1
    } opcode_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_WIRE_MODE     = 8'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_HALF_STEP     = 8'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_STEPS_PER_REV = 8'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_STEP_PERIOD   = 8'd3;

    // Configuration register reset values.
    localparam logic                 WIRE_MODE_RST     = 1'b1;
    localparam logic                 HALF_STEP_RST     = 1'b0;
    localparam logic [POS_WIDTH-1:0] STEPS_PER_REV_RST = 16'd200;
    localparam logic [POS_WIDTH-1:0] STEP_PERIOD_RST   = 16'hFFFF;

    // Configuration as seen by the step logic.
    typedef struct packed {
        logic                 wire_mode;
        logic                 half_step;
        logic [POS_WIDTH-1:0] steps_per_rev;
        logic [POS_WIDTH-1:0] step_period;
    } cfg_t;

    // Four-wire full-step pattern.
    function automatic logic [COIL_WIDTH-1:0] full_coil(input logic [1:0] idx);
        logic [COIL_WIDTH-1:0] pat;
        unique case (idx)
            2'd0: pat = 4'h5;
            2'd1: pat = 4'h6;
            2'd2: pat = 4'hA;
            2'd3: pat = 4'h9;
        endcase
        return pat;
    endfunction

    // Four-wire half-step pattern.
    function automatic logic [COIL_WIDTH-1:0] half_coil(input logic [2:0] idx);
        logic [COIL_WIDTH-1:0] pat;
        unique case (idx)
            3'd0: pat = 4'h5;
            3'd1: pat = 4'h4;
            3'd2: pat = 4'h6;
            3'd3: pat = 4'h2;
            3'd4: pat = 4'hA;
            3'd5: pat = 4'h8;
            3'd6: pat = 4'h9;
            3'd7: pat = 4'h1;
        endcase
        return pat;
    endfunction

    // Two-wire pattern on bits 0 and 1.
    function automatic logic [COIL_WIDTH-1:0] two_coil(input logic [1:0] idx);
        logic [COIL_WIDTH-1:0] pat;
        unique case (idx)
            2'd0: pat = 4'h2;
            2'd1: pat = 4'h3;
            2'd2: pat = 4'h1;
            2'd3: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

/* sv/ssq_if.sv */
// Channel interfaces of the stepper step sequencer: command, result and
// configuration write. Depends on ssq_pkg.
interface ssq_cmd_if;
    import ssq_pkg::*;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic signed [MOVE_WIDTH-1:0] move_steps;

    modport source (output valid, opcode, move_steps, input ready);
    modport sink   (input valid, opcode, move_steps, output ready);
endinterface

interface ssq_res_if;
    import ssq_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [COIL_WIDTH-1:0] coils;
    logic [REM_WIDTH-1:0]  steps_remaining;
    logic                  step_taken;

    modport source (output valid, coils, steps_remaining, step_taken, input ready);
    modport sink   (input valid, coils, steps_remaining, step_taken, output ready);
endinterface

interface ssq_cfg_if;
    import ssq_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_IDX_WIDTH-1:0]  index;
    logic [CFG_DATA_WIDTH-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/stepper_step_sequencer.sv */
// Stepper step sequencer top level: command register, motor state, result
// register. Depends on ssq_pkg, ssq_if, ssq_cfg_regs and ssq_step_logic.
//
// The sequencer takes one command transaction per clock cycle while its
// results are taken, and returns one result transaction for each, in order.
// A command passes through an input register, where the step logic works
// out the next motor state combinationally, and lands in the result
// register together with the new motor state once the result register is
// free or drained; those two registers lie between a command and its
// result, and the combinational update keeps that rate while results flow.
// While the result register is full and not taken the command side keeps
// taking one more command, then holds ready low. Configuration writes take
// effect on the next cycle and are meant to be issued while no command is
// in flight.
module stepper_step_sequencer
    import ssq_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    ssq_cmd_if.sink   cmd,
    ssq_res_if.source res,
    ssq_cfg_if.sink   cfg
);

    cfg_t cfg_cur;

    // Command register.
    logic                         cmd_valid_reg;
    logic                         cmd_opcode_reg;
    logic signed [MOVE_WIDTH-1:0] cmd_move_reg;

    // Motor state.
    logic [POS_WIDTH-1:0]   tick_count_reg;
    logic [POS_WIDTH-1:0]   position_reg;
    logic [COUNT_WIDTH-1:0] steps_left_reg;
    logic                   forward_reg;
    logic [COIL_WIDTH-1:0]  coil_pattern_reg;
    logic [POS_WIDTH-1:0]   tick_count_next;
    logic [POS_WIDTH-1:0]   position_next;
    logic [COUNT_WIDTH-1:0] steps_left_next;
    logic                   forward_next;
    logic [COIL_WIDTH-1:0]  coil_pattern_next;
    logic                   step_taken_next;

    // Result register.
    logic                  res_valid_reg;
    logic [COIL_WIDTH-1:0] res_coils_reg;
    logic [REM_WIDTH-1:0]  res_remaining_reg;
    logic                  res_taken_reg;

    logic advance;

    ssq_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    ssq_step_logic #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step_logic (
        .cfg               (cfg_cur),
        .opcode            (cmd_opcode_reg),
        .move_steps        (cmd_move_reg),
        .tick_count        (tick_count_reg),
        .position          (position_reg),
        .steps_left        (steps_left_reg),
        .forward           (forward_reg),
        .coil_pattern      (coil_pattern_reg),
        .tick_count_next   (tick_count_next),
        .position_next     (position_next),
        .steps_left_next   (steps_left_next),
        .forward_next      (forward_next),
        .coil_pattern_next (coil_pattern_next),
        .step_taken        (step_taken_next)
    );

    // The registered command moves on when the result register is free or drained.
    assign advance   = cmd_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !cmd_valid_reg || advance;

    assign res.valid           = res_valid_reg;
    assign res.coils           = res_coils_reg;
    assign res.steps_remaining = res_remaining_reg;
    assign res.step_taken      = res_taken_reg;

    // Control state and motor state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg    <= 1'b0;
            res_valid_reg    <= 1'b0;
            tick_count_reg   <= '0;
            position_reg     <= '0;
            steps_left_reg   <= '0;
            forward_reg      <= 1'b0;
            coil_pattern_reg <= '0;
        end
        else
        begin
            if (cmd.ready)
                cmd_valid_reg <= cmd.valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
            if (advance)
            begin
                tick_count_reg   <= tick_count_next;
                position_reg     <= position_next;
                steps_left_reg   <= steps_left_next;
                forward_reg      <= forward_next;
                coil_pattern_reg <= coil_pattern_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            cmd_opcode_reg <= cmd.opcode;
            cmd_move_reg   <= cmd.move_steps;
        end
        if (advance)
        begin
            res_coils_reg     <= coil_pattern_next;
            res_remaining_reg <= REM_WIDTH'(steps_left_next);
            res_taken_reg     <= step_taken_next;
        end
    end

endmodule

/* sv/ssq_cfg_regs.sv */
// Configuration register file of the stepper step sequencer.
// Depends on ssq_pkg and ssq_cfg_if.
module ssq_cfg_regs
    import ssq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ssq_cfg_if.sink   cfg,
    output cfg_t      cfg_out
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken.
    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    // Decode a write transaction; unknown indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_WIRE_MODE:     cfg_next.wire_mode     = cfg.data[0];
                CFG_HALF_STEP:     cfg_next.half_step     = cfg.data[0];
                CFG_STEPS_PER_REV: cfg_next.steps_per_rev = cfg.data[POS_WIDTH-1:0];
                CFG_STEP_PERIOD:   cfg_next.step_period   = cfg.data[POS_WIDTH-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wire_mode     <= WIRE_MODE_RST;
            cfg_reg.half_step     <= HALF_STEP_RST;
            cfg_reg.steps_per_rev <= STEPS_PER_REV_RST;
            cfg_reg.step_period   <= STEP_PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* sv/ssq_step_logic.sv */
// Combinational next-state logic of the stepper step sequencer: move
// decoding, period counting, position wrap and coil lookup. Depends on ssq_pkg.
module ssq_step_logic
    import ssq_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  cfg_t                         cfg,
    input  logic                         opcode,
    input  logic signed [MOVE_WIDTH-1:0] move_steps,
    input  logic [POS_WIDTH-1:0]         tick_count,
    input  logic [POS_WIDTH-1:0]         position,
    input  logic [COUNT_WIDTH-1:0]       steps_left,
    input  logic                         forward,
    input  logic [COIL_WIDTH-1:0]        coil_pattern,
    output logic [POS_WIDTH-1:0]         tick_count_next,
    output logic [POS_WIDTH-1:0]         position_next,
    output logic [COUNT_WIDTH-1:0]       steps_left_next,
    output logic                         forward_next,
    output logic [COIL_WIDTH-1:0]        coil_pattern_next,
    output logic                         step_taken
);

    logic [MOVE_WIDTH:0]   mag;
    logic [MOVE_WIDTH+1:0] mag_scaled;
    logic                  mag_sat;
    logic [COUNT_WIDTH-1:0] move_count;
    logic                  period_end;
    logic [POS_WIDTH:0]    pos_inc;
    logic [POS_WIDTH-1:0]  pos_fwd;
    logic [POS_WIDTH-1:0]  pos_base;
    logic [POS_WIDTH-1:0]  pos_step;
    logic [2:0]            coil_idx;
    logic [COIL_WIDTH-1:0] coil_step;

    // Magnitude of the move count, doubled in half-step mode, saturated.
    always_comb
    begin
        if (move_steps[MOVE_WIDTH-1])
            mag = (MOVE_WIDTH+1)'(1 << MOVE_WIDTH) - {1'b0, move_steps};
        else
            mag = {1'b0, move_steps};
        mag_scaled = cfg.half_step ? {mag, 1'b0} : {1'b0, mag};
        if (COUNT_WIDTH < MOVE_WIDTH + 2)
            mag_sat = (mag_scaled >> COUNT_WIDTH) != '0;
        else
            mag_sat = 1'b0;
        move_count = mag_sat ? '1 : COUNT_WIDTH'(mag_scaled);
    end

    // Position after one step; a zero revolution length wraps at 16 bits.
    always_comb
    begin
        pos_inc = {1'b0, position} + (POS_WIDTH+1)'(1);
        if ((cfg.steps_per_rev != '0) && (pos_inc[POS_WIDTH-1:0] >= cfg.steps_per_rev))
            pos_fwd = '0;
        else
            pos_fwd = pos_inc[POS_WIDTH-1:0];
        pos_base = (position == '0) ? cfg.steps_per_rev : position;
        pos_step = forward ? pos_fwd : (pos_base - POS_WIDTH'(1));
    end

    // Coil pattern for the new position; two-wire half-step upper indexes hold.
    always_comb
    begin
        coil_idx = cfg.half_step ? pos_step[2:0] : {1'b0, pos_step[1:0]};
        if (cfg.wire_mode)
            coil_step = cfg.half_step ? half_coil(coil_idx) : full_coil(coil_idx[1:0]);
        else if (!coil_idx[2])
            coil_step = two_coil(coil_idx[1:0]);
        else
            coil_step = coil_pattern;
    end

    assign period_end = (tick_count >= cfg.step_period);

    // Next state for a move command or a tick.
    always_comb
    begin
        tick_count_next   = tick_count;
        position_next     = position;
        steps_left_next   = steps_left;
        forward_next      = forward;
        coil_pattern_next = coil_pattern;
        step_taken        = 1'b0;
        unique case (opcode)
            OP_MOVE:
            begin
                steps_left_next = move_count;
                if (move_steps != '0)
                    forward_next = ~move_steps[MOVE_WIDTH-1];
            end
            OP_TICK:
            begin
                if (period_end)
                begin
                    tick_count_next = '0;
                    if (steps_left != '0)
                    begin
                        position_next     = pos_step;
                        steps_left_next   = steps_left - COUNT_WIDTH'(1);
                        coil_pattern_next = coil_step;
                        step_taken        = 1'b1;
                    end
                end
                else
                begin
                    tick_count_next = tick_count + POS_WIDTH'(1);
                end
            end
        endcase
    end

endmodule

/* sv/ssq_checker.sv */
// Port-level checker for the stepper step sequencer and its bind.
// Depends on ssq_pkg and stepper_step_sequencer.
module ssq_checker
    import ssq_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_valid,
    input logic                  cmd_ready,
    input logic                  res_valid,
    input logic                  res_ready,
    input logic [COIL_WIDTH-1:0] res_coils,
    input logic [REM_WIDTH-1:0]  res_steps_remaining,
    input logic                  res_step_taken
);

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_coils)
            && $stable(res_steps_remaining) && $stable(res_step_taken))
    else $error("result payload changed while stalled");

    // Commands are refused only while a result waits to be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> res_valid && !res_ready)
    else $error("command side stalled without a stalled result");

    // Once an accepted command has passed the input register, a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |-> ##2 res_valid)
    else $error("no result two cycles after an accepted command");

endmodule

bind stepper_step_sequencer ssq_checker u_ssq_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_valid           (cmd.valid),
    .cmd_ready           (cmd.ready),
    .res_valid           (res.valid),
    .res_ready           (res.ready),
    .res_coils           (res.coils),
    .res_steps_remaining (res.steps_remaining),
    .res_step_taken      (res.step_taken)
);

/* test/tb_top.sv */
// Testbench for the stepper step sequencer: a scoreboard class with its own step predictor,
// plus plain driver tasks for command and configuration writes, and a result-side driver.
// Depends on ssq_pkg, ssq_if and stepper_step_sequencer.
`timescale 1ns / 1ps

module tb_top;
    import ssq_pkg::*;

    localparam int CNT_W      = COUNT_WIDTH_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int PHASES     = 8;
    localparam int PHASE_ITEMS = 110;

    // One predicted result transaction.
    typedef struct packed {
        logic [COIL_WIDTH-1:0] coils;
        logic [REM_WIDTH-1:0]  remaining;
        logic                  taken;
    } step_result_t;

    // Scoreboard: mirrors the motor state and holds the results still due.
    class step_scoreboard;
        logic                 wire4;
        logic                 half;
        logic [POS_WIDTH-1:0] rev_len;
        logic [POS_WIDTH-1:0] period;
        logic [15:0]          tick_cnt;
        logic [POS_WIDTH-1:0] pos;
        logic [CNT_W-1:0]     left;
        logic                 fwd;
        logic [3:0]           pattern;
        logic [3:0]           full_seq [4];
        logic [3:0]           half_seq [8];
        logic [3:0]           pair_seq [4];
        step_result_t         due_q [$];
        int                   errors;
        int                   commands;
        int                   results;
        int                   steps;

        function new();
            full_seq = '{4'h5, 4'h6, 4'hA, 4'h9};
            half_seq = '{4'h5, 4'h4, 4'h6, 4'h2, 4'hA, 4'h8, 4'h9, 4'h1};
            pair_seq = '{4'h2, 4'h3, 4'h1, 4'h0};
            wire4    = 1'b1;
            half     = 1'b0;
            rev_len  = 16'd200;
            period   = 16'hFFFF;
            tick_cnt = '0;
            pos      = '0;
            left     = '0;
            fwd      = 1'b0;
            pattern  = '0;
        endfunction

        function void set_register(logic [CFG_IDX_WIDTH-1:0] idx,
                                   logic [CFG_DATA_WIDTH-1:0] value);
            case (idx)
                CFG_WIRE_MODE:     wire4   = value[0];
                CFG_HALF_STEP:     half    = value[0];
                CFG_STEPS_PER_REV: rev_len = value;
                CFG_STEP_PERIOD:   period  = value;
                default: ;
            endcase
        endfunction

        // Move the rotor one step and look up the new coil pattern.
        function void advance();
            logic [2:0] idx;
            if (fwd) begin
                pos = pos + 16'd1;
                if (rev_len != 0 && pos >= rev_len)
                    pos = '0;
            end else begin
                if (pos == 0)
                    pos = rev_len;
                pos = pos - 16'd1;
            end
            left = left - 1'b1;
            idx = half ? pos[2:0] : {1'b0, pos[1:0]};
            if (wire4)
                pattern = half ? half_seq[pos[2:0]] : full_seq[pos[1:0]];
            else if (idx < 3'd4)
                pattern = pair_seq[idx[1:0]];
        endfunction

        // Predict the result of one accepted command transaction.
        function void note_command(opcode_t op, logic [MOVE_WIDTH-1:0] count);
            longint unsigned mag;
            step_result_t    res;
            res.taken = 1'b0;
            if (op == OP_MOVE) begin
                mag = count[15] ? (longint'(65536) - count) : longint'(count);
                if (half)
                    mag = mag << 1;
                if (mag > (longint'(1) << CNT_W) - 1)
                    mag = (longint'(1) << CNT_W) - 1;
                left = mag[CNT_W-1:0];
                if (count != 0)
                    fwd = ~count[15];
            end else begin
                if (tick_cnt >= period) begin
                    tick_cnt = '0;
                    if (left != 0) begin
                        advance();
                        res.taken = 1'b1;
                        steps++;
                    end
                end else begin
                    tick_cnt = tick_cnt + 16'd1;
                end
            end
            res.coils     = pattern;
            res.remaining = left[REM_WIDTH-1:0];
            due_q.push_back(res);
            commands++;
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one result transaction with the oldest prediction.
        task check_result(logic [COIL_WIDTH-1:0] coils, logic [REM_WIDTH-1:0] remaining,
                          logic taken);
            step_result_t exp;
            if (due_q.size() == 0) begin
                report($sformatf("result with nothing due: coils=%h rem=%0d taken=%b",
                                 coils, remaining, taken));
                return;
            end
            exp = due_q.pop_front();
            results++;
            if (coils !== exp.coils)
                report($sformatf("result %0d coils %h, expected %h",
                                 results, coils, exp.coils));
            if (remaining !== exp.remaining)
                report($sformatf("result %0d steps_remaining %0d, expected %0d",
                                 results, remaining, exp.remaining));
            if (taken !== exp.taken)
                report($sformatf("result %0d step_taken %b, expected %b",
                                 results, taken, exp.taken));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   stall_pct;
    int   hold_cycles;
    int   quiet_cycles;
    step_scoreboard sb = new();

    ssq_cmd_if cmd_if ();
    ssq_res_if res_if ();
    ssq_cfg_if cfg_if ();

    stepper_step_sequencer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Drive every input to a known value before the first edge.
    initial
    begin
        rst_n             = 1'b0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        hold_cycles       = 0;
        cmd_if.valid      = 1'b0;
        cmd_if.opcode     = OP_TICK;
        cmd_if.move_steps = '0;
        res_if.ready      = 1'b1;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = '0;
        cfg_if.data       = '0;
    end

    // Result side: random stalls, or a long hold-off counted down here.
    always @(negedge clk)
    begin
        if (hold_cycles > 0) begin
            res_if.ready = 1'b0;
            hold_cycles  = hold_cycles - 1;
        end else begin
            res_if.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor: check results, then feed accepted commands and writes to the predictor.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.coils, res_if.steps_remaining, res_if.step_taken);
            if (cmd_if.valid && cmd_if.ready)
                sb.note_command(opcode_t'(cmd_if.opcode), cmd_if.move_steps);
            if (cfg_if.valid && cfg_if.ready)
                sb.set_register(cfg_if.index, cfg_if.data);
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.", sb.due_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one command transaction, with random idle cycles before it.
    task automatic send_command(input opcode_t op, input logic [MOVE_WIDTH-1:0] count);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid      = 1'b0;
            cmd_if.opcode     = opcode_t'($urandom_range(1));
            cmd_if.move_steps = 16'($urandom);
            @(negedge clk);
        end
        cmd_if.valid      = 1'b1;
        cmd_if.opcode     = op;
        cmd_if.move_steps = count;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
    endtask

    // A tick ignores its count, so the count is random.
    task automatic send_tick();
        send_command(OP_TICK, 16'($urandom));
    endtask

    task automatic send_move(input int count);
        send_command(OP_MOVE, 16'(count));
    endtask

    // Stop offering commands and wait until every predicted result is back.
    task automatic settle();
        @(negedge clk);
        cmd_if.valid = 1'b0;
        while (sb.due_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_WIDTH-1:0] idx,
                                  input logic [CFG_DATA_WIDTH-1:0] value);
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // Mostly ticks with short moves, so that steps happen often; a few full-range moves.
    task automatic send_random();
        int r;
        int mag;
        r = $urandom_range(99);
        if (r < 82) begin
            send_tick();
        end else if (r < 96) begin
            mag = $urandom_range(12);
            send_move($urandom_range(1) ? mag : -mag);
        end else begin
            send_command(OP_MOVE, 16'($urandom_range(65535)));
        end
    endtask

    // Main sequence.
    initial
    begin
        int ph;
        int i;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: first tick with coils off, zero move, count extremes.
        send_tick();
        send_move(0);
        send_move(32767);
        send_move(-32767);
        send_move(-32768);
        send_tick();
        settle();

        // Half-step saturation, then stepping backward through zero.
        write_register(CFG_STEP_PERIOD, 16'd0);
        write_register(CFG_HALF_STEP, 16'd1);
        send_move(-32768);
        send_move(32767);
        send_move(-3);
        repeat (3) send_tick();
        // A zero move keeps the direction; ticks then run idle.
        send_move(0);
        repeat (2) send_tick();
        settle();

        // Two-wire half-step with the position wrapping at 16 bits.
        write_register(CFG_WIRE_MODE, 16'd0);
        write_register(CFG_STEPS_PER_REV, 16'd0);
        send_move(-5);
        repeat (5) send_tick();
        settle();

        // Period raised, short revolution, forward wrap.
        write_register(CFG_HALF_STEP, 16'd0);
        write_register(CFG_STEPS_PER_REV, 16'd3);
        write_register(CFG_STEP_PERIOD, 16'd1);
        send_move(5);
        repeat (4) send_tick();

        // Random phases, each with its own register setting and idle pattern.
        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    write_register(CFG_WIRE_MODE, 16'd1);
                    write_register(CFG_HALF_STEP, 16'd0);
                    write_register(CFG_STEPS_PER_REV, 16'd200);
                    write_register(CFG_STEP_PERIOD, 16'd0);
                end
                1: begin
                    write_register(CFG_HALF_STEP, 16'd1);
                    write_register(CFG_STEPS_PER_REV, 16'd7);
                    write_register(CFG_STEP_PERIOD, 16'd1);
                end
                2: begin
                    write_register(CFG_WIRE_MODE, 16'd0);
                    write_register(CFG_HALF_STEP, 16'd0);
                    write_register(CFG_STEPS_PER_REV, 16'd1);
                    write_register(CFG_STEP_PERIOD, 16'd0);
                end
                3: begin
                    write_register(CFG_HALF_STEP, 16'd1);
                    write_register(CFG_STEPS_PER_REV, 16'hFFFF);
                    write_register(CFG_STEP_PERIOD, 16'd2);
                end
                4: begin
                    write_register(CFG_WIRE_MODE, 16'd1);
                    write_register(CFG_STEPS_PER_REV, 16'd0);
                    write_register(CFG_STEP_PERIOD, 16'd0);
                end
                5: begin
                    // The position is likely far above the new revolution length.
                    write_register(CFG_WIRE_MODE, 16'd0);
                    write_register(CFG_STEPS_PER_REV, 16'd5);
                    write_register(CFG_STEP_PERIOD, 16'd3);
                end
                6: begin
                    write_register(CFG_WIRE_MODE, 16'd1);
                    write_register(CFG_HALF_STEP, 16'd0);
                    write_register(CFG_STEPS_PER_REV, 16'd3);
                    write_register(CFG_STEP_PERIOD, 16'hFFFF);
                end
                default: begin
                    // The period drops below the counter left by the previous phase.
                    write_register(CFG_WIRE_MODE, 16'($urandom_range(1)));
                    write_register(CFG_HALF_STEP, 16'($urandom_range(1)));
                    write_register(CFG_STEPS_PER_REV, 16'($urandom_range(65535, 1)));
                    write_register(CFG_STEP_PERIOD, 16'($urandom_range(3)));
                end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 69; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 69; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++) begin
                // Hold the result side off while commands keep coming.
                if (ph == 0 && i == 40)
                    hold_cycles = 300;
                send_random();
            end
        end

        settle();
        repeat (10) @(posedge clk);
        $display("Covered %0d commands and %0d checked results with %0d motor steps,",
                 sb.commands, sb.results, sb.steps);
        $display("over %0d register settings and four idle patterns; %0d mismatches.",
                 PHASES + 4, sb.errors);
        if (sb.errors == 0 && sb.due_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
sv/ssq_pkg.sv
sv/ssq_if.sv
sv/ssq_cfg_regs.sv
sv/ssq_step_logic.sv
sv/stepper_step_sequencer.sv
sv/ssq_checker.sv
test/tb_top.sv
